>>> rtl/core/bbmt_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bbmt_pkg: shared types and constants for the match table
// operation codes, sequencer states and field widths
// ----------------------------------------------------------------------------
package bbmt_pkg;

  // field widths
  localparam int OP_W    = 2;
  localparam int DIR_W   = 2;
  localparam int ID_W    = 6;
  localparam int VAL_W   = 24;
  localparam int MASK_W  = 64;
  localparam int SLOT_W  = DIR_W + ID_W;
  localparam int DEPTH   = 1 << SLOT_W;

  // parameter defaults
  localparam int MAX_PIECES_DEF = 64;
  localparam int TOP_K_DEF      = 3;

  typedef enum logic [OP_W-1:0] {
    OP_WRITE = 2'd0,
    OP_MATCH = 2'd1,
    OP_BUDDY = 2'd2,
    OP_NONE  = 2'd3
  } op_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_WRITE,
    ST_NBR_RD,
    ST_NBR_CHK,
    ST_SCAN,
    ST_FIN
  } state_t;

endpackage

>>> rtl/core/bbmt_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bbmt_if: valid/ready channels of the match table
// query word channel and result word channel
// ----------------------------------------------------------------------------
interface bbmt_in_if;
  logic                         valid;
  logic                         ready;
  logic [bbmt_pkg::OP_W-1:0]    operation;
  logic [bbmt_pkg::DIR_W-1:0]   direction;
  logic [bbmt_pkg::ID_W-1:0]    neighbor_id;
  logic [bbmt_pkg::VAL_W-1:0]   dissimilarity;
  logic [bbmt_pkg::MASK_W-1:0]  available_mask;
  logic [bbmt_pkg::ID_W-1:0]    neighbor_best_opposite;

  modport source (
    output valid, operation, direction, neighbor_id, dissimilarity,
           available_mask, neighbor_best_opposite,
    input  ready
  );
  modport sink (
    input  valid, operation, direction, neighbor_id, dissimilarity,
           available_mask, neighbor_best_opposite,
    output ready
  );
endinterface

interface bbmt_out_if;
  logic                       valid;
  logic                       ready;
  logic                       found;
  logic [bbmt_pkg::ID_W-1:0]  match_id;
  logic                       is_buddy;

  modport source (
    output valid, found, match_id, is_buddy,
    input  ready
  );
  modport sink (
    input  valid, found, match_id, is_buddy,
    output ready
  );
endinterface

>>> rtl/core/best_buddy_match_table.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// best_buddy_match_table: edge dissimilarity table with match queries
// stores one value per direction and neighbor id, answers best-match and
// best-buddy queries by scanning one direction through a shared comparator
// ----------------------------------------------------------------------------
//
// channel   dir   handshake        payload
// in_bus    in    valid / ready    operation, direction, neighbor_id,
//                                  dissimilarity, available_mask,
//                                  neighbor_best_opposite
// out_bus   out   valid / ready    found, match_id, is_buddy
// cfg_*     in    cfg_we           cfg_wdata -> own_id
//
// one word at a time; ready only while the sequencer is idle
// write: one table store; best match: a scan of the direction; buddy check:
//   a neighbor read and precheck, then the scan (skipped when the neighbor
//   fails its precheck); each scan is a one-entry-per-cycle table read feeding a single comparator
// a finished result waits in the output register, so the next word is
//   taken while the previous result is still stalled
// rst_n (sync, active low) clears the sequencer, valid bits and own_id;
//   table contents stay undefined until written
//
module best_buddy_match_table #(
  parameter int MAX_PIECES = bbmt_pkg::MAX_PIECES_DEF,
  parameter int TOP_K      = bbmt_pkg::TOP_K_DEF
) (
  input  logic                      clk,
  input  logic                      rst_n,
  bbmt_in_if.sink                   in_bus,
  bbmt_out_if.source                out_bus,
  input  logic                      cfg_we,
  input  logic [bbmt_pkg::ID_W-1:0] cfg_wdata
);

  localparam int ID_W   = bbmt_pkg::ID_W;
  localparam int VAL_W  = bbmt_pkg::VAL_W;
  localparam int SLOT_W = bbmt_pkg::SLOT_W;
  localparam int CNT_W  = ID_W + 1;
  localparam int AW     = $clog2(TOP_K + 1);

  localparam logic [CNT_W-1:0] N_LIM = CNT_W'(MAX_PIECES);
  localparam logic [AW-1:0]    K_LIM = AW'(TOP_K);

  // sequencer and item registers
  bbmt_pkg::state_t state_r, state_nxt;
  bbmt_pkg::op_t    op_r, op_nxt;
  logic [bbmt_pkg::DIR_W-1:0]  dir_r, dir_nxt;
  logic [ID_W-1:0]             nid_r, nid_nxt;
  logic [VAL_W-1:0]            val_r, val_nxt;
  logic [bbmt_pkg::MASK_W-1:0] avail_r, avail_nxt;
  logic [ID_W-1:0]             nbest_r, nbest_nxt;
  logic [ID_W-1:0]             own_id_r;

  // scan pipeline
  logic [CNT_W-1:0] idx_r, idx_nxt;
  logic             p_vld_r, p_vld_nxt;
  logic [ID_W-1:0]  p_id_r, p_id_nxt;

  // accumulators
  logic [VAL_W-1:0] nv_r, nv_nxt;
  logic             found_r, found_nxt;
  logic [VAL_W-1:0] best_r, best_nxt;
  logic [ID_W-1:0]  best_id_r, best_id_nxt;
  logic [AW-1:0]    ahead_r, ahead_nxt;
  logic             chk_ok_r, chk_ok_nxt;

  // output register
  logic             out_valid_r, out_valid_nxt;
  logic             out_found_r, out_found_nxt;
  logic [ID_W-1:0]  out_match_r, out_match_nxt;
  logic             out_buddy_r, out_buddy_nxt;

  // table storage
  logic [VAL_W-1:0]        mem [bbmt_pkg::DEPTH];
  logic [VAL_W-1:0]        rd_data_r;
  logic [bbmt_pkg::DEPTH-1:0] valid_r;
  logic                    mem_we, mem_re, vld_set;
  logic [SLOT_W-1:0]       mem_addr;

  // shared comparator
  logic [VAL_W-1:0] cmp_b;
  logic [ID_W-1:0]  cmp_bid;
  logic             cmp_lt;

  logic in_acc;
  logic nid_in_range;

  assign in_bus.ready     = (state_r == bbmt_pkg::ST_IDLE);
  assign in_acc           = in_bus.valid && in_bus.ready;
  assign out_bus.valid    = out_valid_r;
  assign out_bus.found    = out_found_r;
  assign out_bus.match_id = out_match_r;
  assign out_bus.is_buddy = out_buddy_r;

  assign nid_in_range = ({1'b0, nid_r} < N_LIM);

  // one ranking compare: value first, then lower id
  // for a match query the candidate id always exceeds best_id, so this
  // reduces to a strict value compare and ties stay with the lower id
  assign cmp_b   = (op_r == bbmt_pkg::OP_MATCH) ? best_r : nv_r;
  assign cmp_bid = (op_r == bbmt_pkg::OP_MATCH) ? best_id_r : nid_r;
  assign cmp_lt  = (rd_data_r < cmp_b) || ((rd_data_r == cmp_b) && (p_id_r < cmp_bid));

  // config register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      own_id_r <= '0;
    end else if (cfg_we) begin
      own_id_r <= cfg_wdata;
    end
  end

  // table memory, registered read
  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_addr] <= val_r;
    end
    if (mem_re) begin
      rd_data_r <= mem[mem_addr];
    end
  end

  // per-entry valid bits
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= '0;
    end else if (vld_set) begin
      valid_r[mem_addr] <= 1'b1;
    end
  end

  // state register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= bbmt_pkg::ST_IDLE;
      idx_r       <= '0;
      p_vld_r     <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      idx_r       <= idx_nxt;
      p_vld_r     <= p_vld_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // payload and accumulator registers
  always_ff @(posedge clk) begin
    op_r        <= op_nxt;
    dir_r       <= dir_nxt;
    nid_r       <= nid_nxt;
    val_r       <= val_nxt;
    avail_r     <= avail_nxt;
    nbest_r     <= nbest_nxt;
    p_id_r      <= p_id_nxt;
    nv_r        <= nv_nxt;
    found_r     <= found_nxt;
    best_r      <= best_nxt;
    best_id_r   <= best_id_nxt;
    ahead_r     <= ahead_nxt;
    chk_ok_r    <= chk_ok_nxt;
    out_found_r <= out_found_nxt;
    out_match_r <= out_match_nxt;
    out_buddy_r <= out_buddy_nxt;
  end

  // sequencer
  always_comb begin
    state_nxt     = state_r;
    op_nxt        = op_r;
    dir_nxt       = dir_r;
    nid_nxt       = nid_r;
    val_nxt       = val_r;
    avail_nxt     = avail_r;
    nbest_nxt     = nbest_r;
    idx_nxt       = idx_r;
    p_vld_nxt     = 1'b0;
    p_id_nxt      = p_id_r;
    nv_nxt        = nv_r;
    found_nxt     = found_r;
    best_nxt      = best_r;
    best_id_nxt   = best_id_r;
    ahead_nxt     = ahead_r;
    chk_ok_nxt    = chk_ok_r;
    out_valid_nxt = out_valid_r && !out_bus.ready;
    out_found_nxt = out_found_r;
    out_match_nxt = out_match_r;
    out_buddy_nxt = out_buddy_r;
    mem_we        = 1'b0;
    mem_re        = 1'b0;
    vld_set       = 1'b0;
    mem_addr      = {dir_r, nid_r};

    // compare stage: entry read last cycle is checked here
    if (p_vld_r) begin
      if (op_r == bbmt_pkg::OP_MATCH) begin
        if (!found_r || cmp_lt) begin
          found_nxt   = 1'b1;
          best_nxt    = rd_data_r;
          best_id_nxt = p_id_r;
        end
      end else if (cmp_lt && (ahead_r < K_LIM)) begin
        ahead_nxt = ahead_r + AW'(1);
      end
    end

    case (state_r)
      bbmt_pkg::ST_IDLE: begin
        if (in_acc) begin
          op_nxt      = bbmt_pkg::op_t'(in_bus.operation);
          dir_nxt     = in_bus.direction;
          nid_nxt     = in_bus.neighbor_id;
          val_nxt     = in_bus.dissimilarity;
          avail_nxt   = in_bus.available_mask;
          nbest_nxt   = in_bus.neighbor_best_opposite;
          idx_nxt     = '0;
          found_nxt   = 1'b0;
          best_id_nxt = '0;
          ahead_nxt   = '0;
          chk_ok_nxt  = 1'b0;
          case (bbmt_pkg::op_t'(in_bus.operation))
            bbmt_pkg::OP_WRITE: state_nxt = bbmt_pkg::ST_WRITE;
            bbmt_pkg::OP_MATCH: state_nxt = bbmt_pkg::ST_SCAN;
            bbmt_pkg::OP_BUDDY: state_nxt = bbmt_pkg::ST_NBR_RD;
            default:            state_nxt = bbmt_pkg::ST_FIN;
          endcase
        end
      end
      bbmt_pkg::ST_WRITE: begin
        // out-of-range ids are dropped
        if (nid_in_range) begin
          mem_we  = 1'b1;
          vld_set = 1'b1;
        end
        state_nxt = bbmt_pkg::ST_FIN;
      end
      bbmt_pkg::ST_NBR_RD: begin
        // fetch the neighbor's own value and run the cheap prechecks
        mem_re     = 1'b1;
        chk_ok_nxt = nid_in_range && valid_r[mem_addr] && (nbest_r == own_id_r);
        state_nxt  = bbmt_pkg::ST_NBR_CHK;
      end
      bbmt_pkg::ST_NBR_CHK: begin
        nv_nxt    = rd_data_r;
        state_nxt = chk_ok_r ? bbmt_pkg::ST_SCAN : bbmt_pkg::ST_FIN;
      end
      bbmt_pkg::ST_SCAN: begin
        mem_addr = {dir_r, idx_r[ID_W-1:0]};
        if (idx_r < N_LIM) begin
          mem_re    = 1'b1;
          p_vld_nxt = valid_r[mem_addr] &&
                      ((op_r != bbmt_pkg::OP_MATCH) || avail_r[idx_r[ID_W-1:0]]);
          p_id_nxt  = idx_r[ID_W-1:0];
          idx_nxt   = idx_r + CNT_W'(1);
        end else begin
          // last entry is compared this cycle
          state_nxt = bbmt_pkg::ST_FIN;
        end
      end
      bbmt_pkg::ST_FIN: begin
        if (!out_valid_r || out_bus.ready) begin
          out_valid_nxt = 1'b1;
          out_found_nxt = found_r;
          out_match_nxt = best_id_r;
          out_buddy_nxt = (op_r == bbmt_pkg::OP_BUDDY) && chk_ok_r && (ahead_r < K_LIM);
          state_nxt     = bbmt_pkg::ST_IDLE;
        end
      end
      default: begin
        state_nxt = bbmt_pkg::ST_IDLE;
      end
    endcase
  end

`ifndef NO_ASSERTIONS
  // a word taken closes the input until its result is queued
  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    in_acc |=> !in_bus.ready)
    else $error("input ready right after an accepted word");

  // no match must report id zero
  a_nomatch_zero_id: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && !out_found_r) |-> (out_match_r == '0))
    else $error("match id nonzero without a match");

  // a result carries at most one kind of answer
  a_one_answer: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> !(out_found_r && out_buddy_r))
    else $error("found and is_buddy both set");

  // rank counter saturates at the top-k bound
  a_ahead_bound: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == bbmt_pkg::ST_SCAN || state_r == bbmt_pkg::ST_FIN) |-> (ahead_r <= K_LIM))
    else $error("rank counter beyond top-k");

  // compare stage only runs behind a scan read
  a_cmp_after_scan: assert property (@(posedge clk) disable iff (!rst_n)
    p_vld_r |-> $past(state_r == bbmt_pkg::ST_SCAN))
    else $error("compare without a scan read");
`endif

endmodule
